FILE: rtl/core/rrss_pkg.sv
// Package for the round-robin slice scheduler: operation and status codes,
// payload structs, configuration address map and default sizes.
// No dependencies.
package rrss_pkg;

  localparam int unsigned MAX_JOBS_DEF = 16;

  localparam logic [7:0] QUANTUM_RESET = 8'd2;

  // Configuration port: 32-bit registers at byte address 4*i.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_QUANTUM = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_STEP  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_RAN     = 3'd2,
    ST_IDLE    = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] burst_time;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  job_index;
    logic [31:0] wait_time;
    logic [31:0] response_time;
    logic [15:0] remaining_time;
    logic        job_done;
  } out_item_t;

endpackage

FILE: rtl/core/round_robin_slice_scheduler.sv
// Round-robin slice scheduler: job table, scan sequencer and result register.
// Depends on rrss_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i) takes one transaction
//    per operation: add a job, run one time slice, or clear table and clock.
//  - Output channel (out_valid_o / out_stall_i / out_data_o) returns one
//    transaction per add, run or clear; an unknown operation code returns none.
//  - time_quantum sits at byte address 0 of the APB port; write it while idle.
//  - Sequence: add and clear go through EXEC and POST, then the result
//    register. A run goes through EXEC, a READ and a CHECK for each of k table
//    slots scanned (1 to MAX_JOBS), then POST: each slot costs a memory read
//    and a check in the shared unit. One transaction at a time.
//  - in_stall_o is high while a transaction is in progress.
//  - The result register parts the sides: a new transaction can be accepted
//    while a result waits; the next result holds until the slot frees up.
//  - Reset empties the table (job count, pending count, pointer and clock go
//    to zero) and sets time_quantum to 2. No clearing pass is needed: only
//    slots below the job count are ever read, and each was written by an add.
module round_robin_slice_scheduler #(
  parameter int unsigned MAX_JOBS = rrss_pkg::MAX_JOBS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rrss_pkg::in_item_t         in_data_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rrss_pkg::out_item_t        out_data_o,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rrss_pkg::APB_AW-1:0] paddr,
  input  logic [rrss_pkg::APB_DW-1:0] pwdata,
  output logic [rrss_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  import rrss_pkg::*;

  localparam int unsigned IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_POST  = 3'd4;

  function automatic logic [3:0] slot_to_index(logic [IW-1:0] slot);
    logic [IW+3:0] wide;
    wide = {4'b0000, slot};
    return wide[3:0];
  endfunction

  // Control state
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] job_count_q, job_count_d;
  logic [CW-1:0] pending_q, pending_d;
  logic [IW-1:0] next_job_q, next_job_d;
  logic [31:0]   elapsed_q, elapsed_d;
  logic [7:0]    quantum_q;
  logic [IW-1:0] scan_idx_q, scan_idx_d;
  logic [CW-1:0] scan_n_q, scan_n_d;
  logic          out_valid_q;

  // Payload state
  logic [1:0]    op_q, op_d;
  logic [15:0]   burst_q, burst_d;
  out_item_t     res_q, res_d;
  out_item_t     out_q;

  // Job table
  logic [15:0]   table_mem [MAX_JOBS];
  logic [15:0]   rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;

  // Shared compare/subtract unit and slot increment
  logic [15:0]   quantum_eff;
  logic [15:0]   ticks;
  logic [15:0]   rem_new;
  logic [CW-1:0] idx_inc;
  logic [IW-1:0] idx_wrap;
  logic          out_load;
  logic          cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_QUANTUM);

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1] == REG_QUANTUM) begin
      prdata = {{(APB_DW-8){1'b0}}, quantum_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else if (cfg_wr) begin
      quantum_q <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Job table: one write port, one registered read at the scan pointer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= table_mem[scan_idx_q];
  end

  // ---------------------------------------------------------------------------
  // Shared unit: clip the slice to the quantum, wrap the slot pointer
  // ---------------------------------------------------------------------------
  assign quantum_eff = {8'h00, (quantum_q == 8'h00) ? 8'h01 : quantum_q};
  assign ticks       = (rd_q < quantum_eff) ? rd_q : quantum_eff;
  assign rem_new     = rd_q - ticks;
  assign idx_inc     = CW'(scan_idx_q) + CW'(1);
  assign idx_wrap    = (idx_inc >= job_count_q) ? '0 : idx_inc[IW-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_POST) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    job_count_d = job_count_q;
    pending_d   = pending_q;
    next_job_d  = next_job_q;
    elapsed_d   = elapsed_q;
    scan_idx_d  = scan_idx_q;
    scan_n_d    = scan_n_q;
    op_d        = op_q;
    burst_d     = burst_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = job_count_q[IW-1:0];
    mem_wdata   = burst_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.operation;
          burst_d = in_data_i.burst_time;
          // Drop unknown operation codes without a result
          if (in_data_i.operation == OP_ADD || in_data_i.operation == OP_STEP ||
              in_data_i.operation == OP_CLEAR) begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        res_d   = '0;
        state_d = S_POST;
        case (op_q)
          OP_ADD: begin
            if (job_count_q >= CW'(MAX_JOBS)) begin
              res_d.status = ST_FULL;
            end else begin
              mem_we               = 1'b1;
              job_count_d          = job_count_q + CW'(1);
              if (burst_q != 16'h0000) begin
                pending_d = pending_q + CW'(1);
              end
              res_d.status         = ST_ADDED;
              res_d.job_index      = slot_to_index(job_count_q[IW-1:0]);
              res_d.remaining_time = burst_q;
            end
          end
          OP_STEP: begin
            if (pending_q == '0 || job_count_q == '0) begin
              res_d.status = ST_IDLE;
            end else begin
              scan_idx_d = (CW'(next_job_q) < job_count_q) ? next_job_q : '0;
              scan_n_d   = '0;
              state_d    = S_READ;
            end
          end
          OP_CLEAR: begin
            job_count_d  = '0;
            pending_d    = '0;
            next_job_d   = '0;
            elapsed_d    = '0;
            res_d.status = ST_CLEARED;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_READ: begin
        state_d = S_CHECK;
      end

      S_CHECK: begin
        if (rd_q != 16'h0000) begin
          // Run the slice and write back the remaining time
          mem_we    = 1'b1;
          mem_waddr = scan_idx_q;
          mem_wdata = rem_new;
          elapsed_d = elapsed_q + 32'(ticks);
          if (rem_new == 16'h0000 && pending_q != '0) begin
            pending_d = pending_q - CW'(1);
          end
          next_job_d           = idx_wrap;
          res_d                = '0;
          res_d.status         = ST_RAN;
          res_d.job_index      = slot_to_index(scan_idx_q);
          res_d.wait_time      = elapsed_q;
          res_d.response_time  = elapsed_q + 32'(ticks);
          res_d.remaining_time = rem_new;
          res_d.job_done       = (rem_new == 16'h0000);
          state_d              = S_POST;
        end else if (scan_n_q + CW'(1) >= job_count_q) begin
          res_d        = '0;
          res_d.status = ST_IDLE;
          state_d      = S_POST;
        end else begin
          scan_n_d   = scan_n_q + CW'(1);
          scan_idx_d = idx_wrap;
          state_d    = S_READ;
        end
      end

      S_POST: begin
        // Hold the result until the output register frees up
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_count_q <= '0;
      pending_q   <= '0;
      next_job_q  <= '0;
      elapsed_q   <= '0;
      scan_idx_q  <= '0;
      scan_n_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_count_q <= job_count_d;
      pending_q   <= pending_d;
      next_job_q  <= next_job_d;
      elapsed_q   <= elapsed_d;
      scan_idx_q  <= scan_idx_d;
      scan_n_q    <= scan_n_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    burst_q <= burst_d;
    res_q   <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  a_pending_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= job_count_q)
    else $error("pending count exceeds job count");

  a_count_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_count_q <= CW'(MAX_JOBS))
    else $error("job count exceeds table depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (CW'(scan_idx_q) < job_count_q))
    else $error("scan pointer outside the filled table");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_q))
    else $error("stalled result overwritten");
`endif

endmodule
